// ----- rtl/srmc_pkg.sv -----
// Shared types, codes and constants of the stepper ramp motion controller.
`default_nettype none

package srmc_pkg;

    // Default and ceiling of the channel count parameter.
    localparam int CHANNELS_DEFAULT = 3;
    localparam int CHANNELS_MAX     = 16;

    // Number of channels that have a home switch bit.
    localparam int HOME_BITS = 3;

    // Field widths.
    localparam int OP_W     = 3;
    localparam int CH_W     = 2;
    localparam int POS_W    = 16;
    localparam int PER_W    = 8;
    localparam int HOME_W   = 3;

    // Ramp arithmetic. The scale factor is 8*(d+1)/ramp, at most 20 bits wide.
    // Its square only matters below 128, so it fits in 14 bits.
    localparam int DIV_DW         = 20;
    localparam int DIV_VW         = 14;
    localparam int SF_SMALL_W     = 7;
    localparam int Q_W            = 14;
    localparam int RAMP_SCALE_SH  = 3;
    localparam int RAMP_NUMERATOR = 16320;
    localparam logic [PER_W-1:0] PERIOD_MAX = 8'd255;

    typedef enum logic [OP_W-1:0] {
        OP_MOVE   = 3'd0,
        OP_STEP   = 3'd1,
        OP_HOME   = 3'd2,
        OP_STOP   = 3'd3,
        OP_SETPOS = 3'd4,
        OP_QUERY  = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_DIST,
        S_DIVA_GO,
        S_DIVA,
        S_SQUARE,
        S_DIVB_GO,
        S_DIVB,
        S_PERIOD,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
        logic load_dist;
        logic div_start;
        logic div_sel;
        logic take_sf;
        logic square;
        logic take_q;
        logic set_period;
        logic load_out;
    } srmc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_ramp;
        logic div_busy;
        logic div_done;
        logic sf_special;
    } srmc_sts_t;

endpackage

`default_nettype wire

// ----- rtl/stepper_ramp_motion_controller_unit.sv -----
// Top level of the multi-channel stepper ramp motion controller.
`default_nettype none

// Multi-channel stepper motion controller with a trapezoidal speed ramp. Each
// input word carries one operation (move, step tick, home switches, stop, set
// position, query) for one channel, and produces exactly one result word with
// that channel's position, motion flag, direction and step period after the
// operation; a channel number at or above CHANNELS gives an all-zero result.
// Words are processed one at a time. Operations without ramp arithmetic go
// from the apply step straight to the output step. A step tick on a moving
// channel with a nonzero ramp length computes the period 16320/sf^2 with a
// single radix-2 restoring divider that produces one quotient bit per cycle,
// used once for the scale factor sf = 8*(d+1)/ramp and once more for the
// period, with a short distance, squaring and clamping step around it; when
// sf is zero or 128 or more the second division is skipped. The result sits
// in an output register, so the next word is accepted while an earlier
// result still waits for the downstream side to drop stall.
module stepper_ramp_motion_controller_unit #(
    parameter int CHANNELS = srmc_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [srmc_pkg::OP_W-1:0]           operation,
    input  wire logic [srmc_pkg::CH_W-1:0]           channel,
    input  wire logic signed [srmc_pkg::POS_W-1:0]   target_position,
    input  wire logic [srmc_pkg::PER_W-1:0]          min_period,
    input  wire logic [srmc_pkg::PER_W-1:0]          ramp_period,
    input  wire logic [srmc_pkg::HOME_W-1:0]         home_closed,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [srmc_pkg::POS_W-1:0]        position,
    output logic                                     in_motion,
    output logic                                     direction,
    output logic [srmc_pkg::PER_W-1:0]               step_period
);

    // Command and status between the sequencer and the datapath.
    srmc_pkg::srmc_cmd_t cmd;
    srmc_pkg::srmc_sts_t sts;

    srmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds all channel state, the shared divider and the
    // output word register; it only acts on commands from the sequencer.
    srmc_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .operation       (operation),
        .channel         (channel),
        .target_position (target_position),
        .min_period      (min_period),
        .ramp_period     (ramp_period),
        .home_closed     (home_closed),
        .position        (position),
        .in_motion       (in_motion),
        .direction       (direction),
        .step_period     (step_period)
    );

endmodule

`default_nettype wire

// ----- rtl/srmc_div.sv -----
// Restoring divider that produces one quotient bit per clock cycle.
`default_nettype none

module srmc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [srmc_pkg::DIV_DW-1:0] dividend,
    input  wire logic [srmc_pkg::DIV_VW-1:0] divisor,
    output logic                             busy,
    output logic                             done,
    output logic [srmc_pkg::DIV_DW-1:0]      quotient
);

    localparam int DW  = srmc_pkg::DIV_DW;
    localparam int VW  = srmc_pkg::DIV_VW;
    localparam int CNW = $clog2(DW);
    localparam logic [CNW-1:0] LAST = CNW'(DW - 1);

    logic [VW-1:0]  rem_reg;
    logic [DW-1:0]  quo_reg;
    logic [VW-1:0]  dvs_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [VW:0]    trial;
    logic [VW:0]    diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/srmc_datapath.sv -----
// Datapath: per-channel motion state, ramp arithmetic and the output word register.
`default_nettype none

module srmc_datapath #(
    parameter int CHANNELS = srmc_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire srmc_pkg::srmc_cmd_t            cmd,
    output srmc_pkg::srmc_sts_t                 sts,
    input  wire logic [srmc_pkg::OP_W-1:0]      operation,
    input  wire logic [srmc_pkg::CH_W-1:0]      channel,
    input  wire logic signed [srmc_pkg::POS_W-1:0] target_position,
    input  wire logic [srmc_pkg::PER_W-1:0]     min_period,
    input  wire logic [srmc_pkg::PER_W-1:0]     ramp_period,
    input  wire logic [srmc_pkg::HOME_W-1:0]    home_closed,
    output logic signed [srmc_pkg::POS_W-1:0]   position,
    output logic                                in_motion,
    output logic                                direction,
    output logic [srmc_pkg::PER_W-1:0]          step_period
);

    localparam int PW   = srmc_pkg::POS_W;
    localparam int RW   = srmc_pkg::PER_W;
    localparam int QW   = srmc_pkg::Q_W;
    localparam int DW   = srmc_pkg::DIV_DW;
    localparam int VW   = srmc_pkg::DIV_VW;
    localparam int SW   = srmc_pkg::SF_SMALL_W;
    localparam int IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HW   = (CHANNELS > srmc_pkg::HOME_BITS) ? CHANNELS : srmc_pkg::HOME_BITS;

    // Captured input word.
    logic [srmc_pkg::OP_W-1:0]   op_reg;
    logic [srmc_pkg::CH_W-1:0]   ch_reg;
    logic [PW-1:0]               tgt_reg;
    logic [RW-1:0]               pulse_reg;
    logic [RW-1:0]               ramp_reg;
    logic [srmc_pkg::HOME_W-1:0] home_reg;

    // Per-channel state.
    logic [PW-1:0] pos_reg    [CHANNELS];
    logic [PW-1:0] target_reg [CHANNELS];
    logic [PW-1:0] start_reg  [CHANNELS];
    logic [RW-1:0] minp_reg   [CHANNELS];
    logic [RW-1:0] rampp_reg  [CHANNELS];
    logic          moving_reg [CHANNELS];
    logic          dir_reg    [CHANNELS];
    logic [RW-1:0] period_reg [CHANNELS];

    // Ramp working registers.
    logic [PW-1:0] dist_reg;
    logic [DW-1:0] sf_reg;
    logic [VW-1:0] sq_reg;
    logic [QW-1:0] q_reg;

    // Output word register.
    logic [PW-1:0] position_reg;
    logic          in_motion_reg;
    logic          direction_reg;
    logic [RW-1:0] step_period_reg;

    logic [IW-1:0]       idx;
    logic                ch_valid;
    logic [HW-1:0]       home_ext;
    logic [CHANNELS-1:0] home_mask;
    logic [PW-1:0]       cur_pos;
    logic [PW-1:0]       cur_tgt;
    logic [PW-1:0]       cur_start;
    logic                cur_moving;
    logic                cur_dir;
    logic [PW-1:0]       step_pos;
    logic [PW:0]         diff_t;
    logic [PW:0]         diff_s;
    logic [PW-1:0]       abs_t;
    logic [PW-1:0]       abs_s;
    logic [DW-1:0]       div_dividend;
    logic [VW-1:0]       div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [DW-1:0]       div_quotient;
    logic [QW-1:0]       q_floor;
    logic [RW-1:0]       ramp_result;

    assign idx      = IW'(ch_reg);
    assign ch_valid = 5'(ch_reg) < 5'(CHANNELS);
    assign home_ext = HW'(home_reg);

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            home_mask[i] = home_ext[i];
        end
    end

    assign cur_pos    = pos_reg[idx];
    assign cur_tgt    = target_reg[idx];
    assign cur_start  = start_reg[idx];
    assign cur_moving = moving_reg[idx];
    assign cur_dir    = dir_reg[idx];

    always_comb
    begin
        if (!cur_moving)
        begin
            step_pos = cur_pos;
        end
        else if (cur_dir)
        begin
            step_pos = cur_pos + 1'b1;
        end
        else
        begin
            step_pos = cur_pos - 1'b1;
        end
    end

    // Distances to target and to start, as 17-bit signed differences and 16-bit magnitudes.
    assign diff_t = {cur_pos[PW-1], cur_pos} - {cur_tgt[PW-1], cur_tgt};
    assign diff_s = {cur_pos[PW-1], cur_pos} - {cur_start[PW-1], cur_start};
    assign abs_t  = diff_t[PW] ? PW'(~diff_t + 1'b1) : diff_t[PW-1:0];
    assign abs_s  = diff_s[PW] ? PW'(~diff_s + 1'b1) : diff_s[PW-1:0];

    always_comb
    begin
        if (cmd.div_sel)
        begin
            div_dividend = DW'(srmc_pkg::RAMP_NUMERATOR);
            div_divisor  = sq_reg;
        end
        else
        begin
            div_dividend = {(PW+1)'(dist_reg) + 1'b1, {srmc_pkg::RAMP_SCALE_SH{1'b0}}};
            div_divisor  = VW'(rampp_reg[idx]);
        end
    end

    srmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Clamp the ramp period to at least the minimum period and at most 255.
    always_comb
    begin
        q_floor = (q_reg < QW'(minp_reg[idx])) ? QW'(minp_reg[idx]) : q_reg;
        if (q_floor > QW'(srmc_pkg::PERIOD_MAX))
        begin
            ramp_result = srmc_pkg::PERIOD_MAX;
        end
        else
        begin
            ramp_result = q_floor[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            ch_reg    <= channel;
            tgt_reg   <= target_position;
            pulse_reg <= min_period;
            ramp_reg  <= ramp_period;
            home_reg  <= home_closed;
        end
        if (cmd.load_dist)
        begin
            dist_reg <= (abs_t < abs_s) ? abs_t : abs_s;
        end
        if (cmd.take_sf)
        begin
            sf_reg <= div_quotient;
        end
        if (cmd.square)
        begin
            sq_reg <= sf_reg[SW-1:0] * sf_reg[SW-1:0];
            q_reg  <= (sf_reg == '0) ? QW'(srmc_pkg::PERIOD_MAX) : '0;
        end
        else if (cmd.take_q)
        begin
            q_reg <= div_quotient[QW-1:0];
        end
        if (cmd.load_out)
        begin
            if (ch_valid)
            begin
                position_reg    <= cur_pos;
                in_motion_reg   <= cur_moving;
                direction_reg   <= cur_dir;
                step_period_reg <= period_reg[idx];
            end
            else
            begin
                position_reg    <= '0;
                in_motion_reg   <= 1'b0;
                direction_reg   <= 1'b0;
                step_period_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]    <= '0;
                target_reg[i] <= '0;
                start_reg[i]  <= '0;
                minp_reg[i]   <= '0;
                rampp_reg[i]  <= '0;
                moving_reg[i] <= 1'b0;
                dir_reg[i]    <= 1'b1;
                period_reg[i] <= srmc_pkg::PERIOD_MAX;
            end
        end
        else if (cmd.apply)
        begin
            case (op_reg)
                srmc_pkg::OP_HOME:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (home_mask[i])
                        begin
                            moving_reg[i] <= 1'b0;
                            pos_reg[i]    <= '0;
                        end
                    end
                end
                srmc_pkg::OP_MOVE:
                begin
                    if (ch_valid && (tgt_reg != cur_pos))
                    begin
                        start_reg[idx]  <= cur_pos;
                        target_reg[idx] <= tgt_reg;
                        dir_reg[idx]    <= $signed(tgt_reg) > $signed(cur_pos);
                        minp_reg[idx]   <= pulse_reg;
                        rampp_reg[idx]  <= ramp_reg;
                        period_reg[idx] <= srmc_pkg::PERIOD_MAX;
                        moving_reg[idx] <= 1'b1;
                    end
                end
                srmc_pkg::OP_STEP:
                begin
                    if (ch_valid)
                    begin
                        pos_reg[idx] <= step_pos;
                        if (step_pos == cur_tgt)
                        begin
                            moving_reg[idx] <= 1'b0;
                        end
                        if (cur_moving && (rampp_reg[idx] == '0))
                        begin
                            period_reg[idx] <= minp_reg[idx];
                        end
                    end
                end
                srmc_pkg::OP_STOP:
                begin
                    if (ch_valid)
                    begin
                        moving_reg[idx] <= 1'b0;
                    end
                end
                srmc_pkg::OP_SETPOS:
                begin
                    if (ch_valid)
                    begin
                        pos_reg[idx] <= tgt_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.set_period)
        begin
            period_reg[idx] <= ramp_result;
        end
    end

    always_comb
    begin
        sts.need_ramp  = ch_valid && (op_reg == srmc_pkg::OP_STEP) && cur_moving
                         && (rampp_reg[idx] != '0);
        sts.div_busy   = div_busy;
        sts.div_done   = div_done;
        sts.sf_special = (sf_reg == '0) || (sf_reg[DW-1:SW] != '0);
    end

    assign position    = position_reg;
    assign in_motion   = in_motion_reg;
    assign direction   = direction_reg;
    assign step_period = step_period_reg;

endmodule

`default_nettype wire

// ----- rtl/srmc_ctrl.sv -----
// Controller state machine that sequences each word through the datapath.
`default_nettype none

module srmc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output srmc_pkg::srmc_cmd_t       cmd,
    input  wire srmc_pkg::srmc_sts_t  sts
);

    srmc_pkg::state_t state_reg;
    srmc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srmc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            srmc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = srmc_pkg::S_APPLY;
                end
            end
            srmc_pkg::S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = sts.need_ramp ? srmc_pkg::S_DIST : srmc_pkg::S_OUT;
            end
            srmc_pkg::S_DIST:
            begin
                cmd.load_dist = 1'b1;
                state_next    = srmc_pkg::S_DIVA_GO;
            end
            srmc_pkg::S_DIVA_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = srmc_pkg::S_DIVA;
            end
            srmc_pkg::S_DIVA:
            begin
                if (sts.div_done)
                begin
                    cmd.take_sf = 1'b1;
                    state_next  = srmc_pkg::S_SQUARE;
                end
            end
            srmc_pkg::S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = sts.sf_special ? srmc_pkg::S_PERIOD : srmc_pkg::S_DIVB_GO;
            end
            srmc_pkg::S_DIVB_GO:
            begin
                cmd.div_sel   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = srmc_pkg::S_DIVB;
            end
            srmc_pkg::S_DIVB:
            begin
                cmd.div_sel = 1'b1;
                if (sts.div_done)
                begin
                    cmd.take_q = 1'b1;
                    state_next = srmc_pkg::S_PERIOD;
                end
            end
            srmc_pkg::S_PERIOD:
            begin
                cmd.set_period = 1'b1;
                state_next     = srmc_pkg::S_OUT;
            end
            srmc_pkg::S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = srmc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srmc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_stall  = state_reg != srmc_pkg::S_IDLE;
    assign out_valid = out_valid_reg;

    // The divider is never restarted while it is still iterating.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // A waiting result word is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.load_out)
        else $error("output word overwritten while stalled");

    // The wait for a quotient only ends when the divider reports done.
    a_diva_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srmc_pkg::S_DIVA && !sts.div_done) |=> (state_reg == srmc_pkg::S_DIVA))
        else $error("left first division early");

    // An accepted word always goes to the apply step next.
    a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == srmc_pkg::S_APPLY))
        else $error("accepted word not applied");

endmodule

`default_nettype wire
